[rtl/swgs_pkg.sv]
// shared types and constants for the swipe gesture scroll detector
// no dependencies; imported by swgs_div, swipe_gesture_scroll_detector, swgs_scroll_checker and the testbench
package swgs_pkg;

    // stream payload widths
    localparam int IN_DATA_W  = 72;  // 67 bits of fields padded to whole bytes
    localparam int OUT_DATA_W = 8;   // 7 bits of fields padded to whole bytes
    localparam int KIND_W     = 2;
    localparam int FINGER_W   = 3;
    localparam int DELTA_W    = 16;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int DIR_W      = 2;
    localparam int INT_W      = 5;

    // divider dividend: 5 * |delta|, at most 5 * 32768
    localparam int NUM_W = 18;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_REQ_FINGERS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_THR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCROLL_THR  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INT     = 2'd3;

    localparam logic [2:0]  RST_REQ_FINGERS = 3'd3;
    localparam logic [15:0] RST_START_THR   = 16'd160;
    localparam logic [14:0] RST_SCROLL_THR  = 15'd16;
    localparam logic [9:0]  RST_MIN_INT     = 10'd16;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    // scroll directions
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    // intensity clamp
    localparam logic [INT_W-1:0] INT_MIN = 5'd1;
    localparam logic [INT_W-1:0] INT_MAX = 5'd20;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } swgs_div_status_t;

endpackage

[rtl/swgs_div.sv]
// iterative clamped divider: intensity = clamp(num / (max(1,dt) << FRAC_BITS), 1, 20)
// one quotient bit per cycle, six bits in all; depends on swgs_pkg
module swgs_div #(
    parameter int FRAC_BITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [swgs_pkg::NUM_W-1:0]          num,
    input  logic [swgs_pkg::TIME_W-1:0]         dt,
    output logic [swgs_pkg::INT_W-1:0]          intensity,
    output swgs_pkg::swgs_div_status_t          status
);
    import swgs_pkg::*;

    // six quotient bits: bit 5 set means the quotient is at least 32
    localparam int Q_W    = 6;
    localparam int DEN_W  = TIME_W + FRAC_BITS;
    localparam int D_W    = DEN_W + Q_W - 1;
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [INT_W-1:0]  int_reg, int_next;

    logic [DEN_W-1:0]  den;
    logic              ge;

    assign den = (dt == '0) ? (DEN_W'(1) << FRAC_BITS) : (DEN_W'(dt) << FRAC_BITS);
    assign ge  = {{(D_W-NUM_W){1'b0}}, rem_reg} >= d_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        int_next  = int_reg;
        if (start)
        begin
            rem_next  = num;
            d_next    = D_W'(den) << (Q_W - 1);
            q_next    = '0;
            step_next = LAST_STEP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - d_reg[NUM_W-1:0];
            end
            q_next = {q_reg[Q_W-2:0], ge};
            d_next = d_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (q_next == '0)
                begin
                    int_next = INT_MIN;
                end
                else if (q_next > Q_W'(INT_MAX))
                begin
                    int_next = INT_MAX;
                end
                else
                begin
                    int_next = q_next[INT_W-1:0];
                end
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            d_reg    <= '0;
            q_reg    <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            int_reg  <= INT_MIN;
        end
        else
        begin
            rem_reg  <= rem_next;
            d_reg    <= d_next;
            q_reg    <= q_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            int_reg  <= int_next;
        end
    end

    assign intensity   = int_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[rtl/swipe_gesture_scroll_detector.sv]
// top level of the swipe gesture scroll detector: sequencer, shared multiplier,
// gesture state and configuration registers; depends on swgs_pkg and swgs_div
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser kind, tdata fingers/dx/dy/time
//  m_*      | out       | m_tvalid/m_tready  | tdata direction/intensity
//  cfg_*    | in        | cfg_we only        | cfg_addr register index, cfg_wdata value
//
// begin, end, unknown kinds and ignored updates stay in idle; an active-gesture update
// adds and checks, one that runs the activation test also makes three passes through
// the shared 32x32 multiplier and compares, and one that scrolls also uses the six-step
// divider and the emit step. reset (rst_n low, asynchronous) clears the gesture state
// and loads the register defaults. one result waits in the output register; the sequencer
// only holds in its emit step when a new result finds the previous one not yet taken.
module swipe_gesture_scroll_detector #(
    parameter int FRAC_BITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] fingers, [18:3] delta_x, [34:19] delta_y, [66:35] time_ms, rest zero
    input  logic [swgs_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [swgs_pkg::KIND_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] direction, [6:2] intensity, [7] zero
    output logic [swgs_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [swgs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swgs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import swgs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,   // waiting for a request
        S_ACC,    // saturating add into the totals
        S_SQX,    // multiplier: |total_x|^2
        S_SQY,    // multiplier: |total_y|^2
        S_SQT,    // multiplier: start threshold squared, add the two squares
        S_CMP,    // activation compare
        S_CHK,    // interval check and direction pick
        S_DIV,    // waiting on the divider
        S_EMIT    // hand the result to the output register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [FINGER_W-1:0] req_reg, req_next;
    logic [15:0]         sthr_reg, sthr_next;
    logic [14:0]         scthr_reg, scthr_next;
    logic [9:0]          minint_reg, minint_next;

    // gesture state
    logic [FINGER_W-1:0]       fingers_reg, fingers_next;
    logic signed [TOTAL_W-1:0] tx_reg, tx_next;
    logic signed [TOTAL_W-1:0] ty_reg, ty_next;
    logic                      active_reg, active_next;
    logic [TIME_W-1:0]         last_reg, last_next;

    // latched request
    logic signed [DELTA_W-1:0] dx_reg, dx_next;
    logic signed [DELTA_W-1:0] dy_reg, dy_next;
    logic [TIME_W-1:0]         now_reg, now_next;

    // multiplier pipe
    logic [2*TOTAL_W-1:0] prod_reg, prod_next;
    logic [2*TOTAL_W-1:0] sum_reg, sum_next;
    logic [TOTAL_W-1:0]   mul_a;
    logic [2*TOTAL_W-1:0] mul_full;

    // result
    logic [DIR_W-1:0]      dir_reg, dir_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // divider hookup
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [TIME_W-1:0] dt;
    logic [INT_W-1:0]  div_int;
    swgs_div_status_t  div_st;

    logic [DELTA_W:0]  ax_d, ay_d;

    function automatic logic [TOTAL_W-1:0] mag32(input logic signed [TOTAL_W-1:0] v);
        return v[TOTAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DELTA_W:0] mag16(input logic signed [DELTA_W-1:0] v);
        logic [DELTA_W:0] e;
        e = {v[DELTA_W-1], v};
        return v[DELTA_W-1] ? (~e + 1'b1) : e;
    endfunction

    function automatic logic signed [TOTAL_W-1:0] sat_add(
        input logic signed [TOTAL_W-1:0] t,
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [TOTAL_W:0] s;
        s = {t[TOTAL_W-1], t} + {{(TOTAL_W-DELTA_W+1){d[DELTA_W-1]}}, d};
        if (s[TOTAL_W] != s[TOTAL_W-1])
        begin
            // overflow: pin to the rail on the side of the true sign
            return s[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
        end
        return s[TOTAL_W-1:0];
    endfunction

    // 5 * |d| as (|d| << 2) + |d|
    function automatic logic [NUM_W-1:0] times5(input logic [DELTA_W:0] a);
        return NUM_W'({a, 2'b00} + {2'b00, a});
    endfunction

    swgs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .num       (div_num),
        .dt        (dt),
        .intensity (div_int),
        .status    (div_st)
    );

    assign dt   = now_reg - last_reg;
    assign ax_d = mag16(dx_reg);
    assign ay_d = mag16(dy_reg);

    // shared squarer, operand picked by the sequencer step
    always_comb
    begin
        case (state_reg)
            S_SQX:   mul_a = mag32(tx_reg);
            S_SQY:   mul_a = mag32(ty_reg);
            S_SQT:   mul_a = TOTAL_W'(sthr_reg);
            default: mul_a = '0;
        endcase
    end

    assign mul_full = mul_a * mul_a;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        sthr_next      = sthr_reg;
        scthr_next     = scthr_reg;
        minint_next    = minint_reg;
        fingers_next   = fingers_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        active_next    = active_reg;
        last_next      = last_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        now_next       = now_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        dir_next       = dir_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_start      = 1'b0;
        div_num        = times5(ay_d);

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_REQ_FINGERS: req_next    = cfg_wdata[FINGER_W-1:0];
                REG_START_THR:   sthr_next   = cfg_wdata;
                REG_SCROLL_THR:  scthr_next  = cfg_wdata[14:0];
                REG_MIN_INT:     minint_next = cfg_wdata[9:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    dx_next  = s_tdata[18:3];
                    dy_next  = s_tdata[34:19];
                    now_next = s_tdata[66:35];
                    case (s_tuser)
                        KIND_BEGIN, KIND_END:
                        begin
                            fingers_next = (s_tuser == KIND_BEGIN) ? s_tdata[2:0] : '0;
                            tx_next      = '0;
                            ty_next      = '0;
                            active_next  = 1'b0;
                            last_next    = '0;
                        end
                        KIND_UPDATE:
                        begin
                            if (fingers_reg == req_reg)
                            begin
                                state_next = S_ACC;
                            end
                        end
                        default: ;  // unknown kind, dropped
                    endcase
                end
            end
            S_ACC:
            begin
                tx_next    = sat_add(tx_reg, dx_reg);
                ty_next    = sat_add(ty_reg, dy_reg);
                state_next = active_reg ? S_CHK : S_SQX;
            end
            S_SQX:
            begin
                prod_next  = mul_full;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sum_next   = prod_reg;
                prod_next  = mul_full;
                state_next = S_SQT;
            end
            S_SQT:
            begin
                sum_next   = sum_reg + prod_reg;
                prod_next  = mul_full;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sum_reg > prod_reg)
                begin
                    active_next = 1'b1;
                    last_next   = now_reg;
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_IDLE;
                if (active_reg && (dt >= TIME_W'(minint_reg)))
                begin
                    // restamp whether or not a scroll comes out
                    last_next = now_reg;
                    if (ay_d > (DELTA_W+1)'(scthr_reg))
                    begin
                        dir_next   = dy_reg[DELTA_W-1] ? DIR_UP : DIR_DOWN;
                        div_num    = times5(ay_d);
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else if (ax_d > (DELTA_W+1)'(scthr_reg))
                    begin
                        dir_next   = dx_reg[DELTA_W-1] ? DIR_LEFT : DIR_RIGHT;
                        div_num    = times5(ax_d);
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait only if the previous result is still held
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, div_int, dir_reg};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= RST_REQ_FINGERS;
            sthr_reg      <= RST_START_THR;
            scthr_reg     <= RST_SCROLL_THR;
            minint_reg    <= RST_MIN_INT;
            fingers_reg   <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            active_reg    <= 1'b0;
            last_reg      <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            now_reg       <= '0;
            prod_reg      <= '0;
            sum_reg       <= '0;
            dir_reg       <= DIR_UP;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            sthr_reg      <= sthr_next;
            scthr_reg     <= scthr_next;
            minint_reg    <= minint_next;
            fingers_reg   <= fingers_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            active_reg    <= active_next;
            last_reg      <= last_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            now_reg       <= now_next;
            prod_reg      <= prod_next;
            sum_reg       <= sum_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // divider only reports back while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIV))
        else $error("divider done outside the divide step");

    // no divide in flight while a new request can be taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_st.busy)
        else $error("divider busy while idle");

    // the divide step is only left once the divider has finished
    a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && !div_st.done |=> (state_reg == S_DIV))
        else $error("left the divide step before the divider finished");

    // a held result always carries an intensity inside the clamp
    a_int_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[6:2] >= INT_MIN) && (out_data_reg[6:2] <= INT_MAX))
        else $error("intensity out of range");

endmodule

[dv/swgs_scroll_checker.sv]
// scoreboard for the swipe gesture scroll detector: watches the event stream and the
// register writes, predicts each scroll request and checks the output stream in order
// depends on swgs_pkg
module swgs_scroll_checker #(
    parameter int FRAC_BITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // [2:0] fingers, [18:3] delta_x, [34:19] delta_y, [66:35] time_ms, rest zero
    input  logic [swgs_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [swgs_pkg::KIND_W-1:0]       s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] direction, [6:2] intensity, [7] zero
    input  logic [swgs_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [swgs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swgs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                failures,
    output int                                scrolls_pending
);

    import swgs_pkg::*;

    typedef struct packed {
        logic [DIR_W-1:0] dir;
        logic [INT_W-1:0] steps;
    } scroll_t;

    localparam longint TOTAL_HI = 64'sd2147483647;
    localparam longint TOTAL_LO = -64'sd2147483648;

    // configuration copy
    logic [2:0]  req_fingers;
    logic [15:0] start_thr;
    logic [14:0] scroll_thr;
    logic [9:0]  min_gap;

    // gesture copy
    logic [2:0]  cur_fingers;
    longint      acc_x;
    longint      acc_y;
    bit          engaged;
    logic [31:0] last_stamp;

    scroll_t     scrolls_due[$];

    function automatic longint clamp_total(input longint v);
        if (v > TOTAL_HI)
            return TOTAL_HI;
        if (v < TOTAL_LO)
            return TOTAL_LO;
        return v;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // floor(5*|d| / (2^FRAC_BITS * max(1,dt))) held to 1..20
    function automatic logic [INT_W-1:0] steps_for(input longint unsigned absd,
                                                   input logic [31:0] dt);
        longint unsigned den;
        longint unsigned q;
        den = (dt == 32'd0) ? 64'd1 : {32'd0, dt};
        den = den << FRAC_BITS;
        q = (5 * absd) / den;
        if (q < INT_MIN)
            return INT_MIN;
        if (q > INT_MAX)
            return INT_MAX;
        return q[INT_W-1:0];
    endfunction

    function automatic void drop_gesture();
        cur_fingers = 3'd0;
        acc_x = 0;
        acc_y = 0;
        engaged = 1'b0;
        last_stamp = 32'd0;
    endfunction

    // one event request into the gesture copy; fired says a scroll comes out of it
    task automatic track_swipe(input logic [KIND_W-1:0] kind, input logic [2:0] fingers,
                               input logic signed [15:0] dx, input logic signed [15:0] dy,
                               input logic [31:0] now, output bit fired,
                               output scroll_t s);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned thr;
        logic [31:0] dt;
        fired = 1'b0;
        s = '0;
        case (kind)
            KIND_BEGIN:
            begin
                drop_gesture();
                cur_fingers = fingers;
            end
            KIND_END:
                drop_gesture();
            KIND_UPDATE:
            begin
                if (cur_fingers == req_fingers)
                begin
                    acc_x = clamp_total(acc_x + dx);
                    acc_y = clamp_total(acc_y + dy);
                    if (!engaged)
                    begin
                        ax = magnitude(acc_x);
                        ay = magnitude(acc_y);
                        thr = start_thr;
                        thr = thr * thr;
                        if (ax * ax + ay * ay > thr)
                        begin
                            engaged = 1'b1;
                            last_stamp = now;
                        end
                    end
                    if (engaged)
                    begin
                        dt = now - last_stamp;
                        if (dt >= min_gap)
                        begin
                            ax = magnitude(dx);
                            ay = magnitude(dy);
                            if (ay > scroll_thr)
                            begin
                                s.dir = (dy < 0) ? DIR_UP : DIR_DOWN;
                                s.steps = steps_for(ay, dt);
                                fired = 1'b1;
                            end
                            else if (ax > scroll_thr)
                            begin
                                s.dir = (dx < 0) ? DIR_LEFT : DIR_RIGHT;
                                s.steps = steps_for(ax, dt);
                                fired = 1'b1;
                            end
                            last_stamp = now;
                        end
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scroll_t got;
        scroll_t want;
        bit      fired;
        if (!rst_n)
        begin
            req_fingers = RST_REQ_FINGERS;
            start_thr = RST_START_THR;
            scroll_thr = RST_SCROLL_THR;
            min_gap = RST_MIN_INT;
            drop_gesture();
            scrolls_due.delete();
            scrolls_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_REQ_FINGERS: req_fingers = cfg_wdata[2:0];
                    REG_START_THR:   start_thr = cfg_wdata[15:0];
                    REG_SCROLL_THR:  scroll_thr = cfg_wdata[14:0];
                    REG_MIN_INT:     min_gap = cfg_wdata[9:0];
                    default:         ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.dir = m_tdata[1:0];
                got.steps = m_tdata[6:2];
                if (scrolls_due.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("scroll request with none predicted: %s %0d %s %0d",
                                 "direction", got.dir, "intensity", got.steps);
                end
                else
                begin
                    want = scrolls_due.pop_front();
                    if (got.dir != want.dir || got.steps != want.steps)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"scroll mismatch: expected direction %0d ",
                                      "intensity %0d, got direction %0d intensity %0d"},
                                     want.dir, want.steps, got.dir, got.steps);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                track_swipe(s_tuser, s_tdata[2:0], s_tdata[18:3], s_tdata[34:19],
                            s_tdata[66:35], fired, want);
                if (fired)
                    scrolls_due.push_back(want);
            end
            scrolls_pending <= scrolls_due.size();
        end
    end

endmodule

[dv/tb_swipe_gesture_scroll_detector.sv]
// testbench top for the swipe gesture scroll detector: clock, reset, event stimulus,
// register writes, output back-pressure and the verdict
// depends on swgs_pkg, swipe_gesture_scroll_detector and swgs_scroll_checker
module tb_swipe_gesture_scroll_detector;

    import swgs_pkg::*;

    // kind code the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // cycles to wait after the last predicted scroll, longer than the slowest event
    localparam int QUIET_CYCLES = 32;
    // length of the long output hold-off
    localparam int HOLD_CYCLES  = 400;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    // [2:0] fingers, [18:3] delta_x, [34:19] delta_y, [66:35] time_ms, rest zero
    logic [IN_DATA_W-1:0]    s_tdata;
    // [1:0] kind
    logic [KIND_W-1:0]       s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    // [1:0] direction, [6:2] intensity, [7] zero
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    int          failures;
    int          scrolls_pending;

    // stimulus knobs and bookkeeping
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          hold_armed;
    int          items_sent;
    logic [31:0] clock_ms;
    logic [2:0]  cfg_fingers;
    int          cfg_min_gap;

    swipe_gesture_scroll_detector #(
        .FRAC_BITS (4)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    swgs_scroll_checker #(
        .FRAC_BITS (4)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .failures        (failures),
        .scrolls_pending (scrolls_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs or drops a scroll request
    initial
    begin
        #20_000_000;
        $display("tb_swipe_gesture_scroll_detector failed");
        $finish;
    end

    // output side: random back-pressure, plus one long hold-off once armed so the
    // output register fills and the block stops taking event requests
    initial
    begin
        int held;
        bit held_once;
        m_tready = 1'b0;
        held = 0;
        held_once = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !held_once)
            begin
                m_tready <= 1'b0;
                held++;
                if (held == HOLD_CYCLES)
                    held_once = 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // random movement: mostly small and medium, sometimes full range or the extremes
    function automatic logic signed [15:0] pick_delta();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 16'(int'($urandom_range(128)) - 64);
        if (r < 80)
            return 16'(int'($urandom_range(4000)) - 2000);
        if (r < 93)
            return 16'($urandom);
        case ($urandom_range(2))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return 16'h0000;
        endcase
    endfunction

    // time between events, spread across the scroll interval so both sides of it show
    // up; a rare full-range jump makes the timestamp wrap
    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(cfg_min_gap + cfg_min_gap / 2 + 2);
        if (r < 88)
            return $urandom_range(3);
        if (r < 97)
            return cfg_min_gap;
        return $urandom;
    endfunction

    // one event request; the sender may idle before offering it, and tvalid only drops
    // after an accepted request
    task automatic send_event(input logic [KIND_W-1:0] kind, input logic [2:0] fingers,
                              input logic signed [15:0] dx, input logic signed [15:0] dy,
                              input logic [31:0] stamp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'd0, stamp, dy, dx, fingers};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // deltas ride along on begin and end too; the block must not care
    task automatic begin_swipe(input logic [2:0] fingers, input logic [31:0] stamp);
        send_event(KIND_BEGIN, fingers, 16'($urandom), 16'($urandom), stamp);
    endtask

    task automatic end_swipe(input logic [31:0] stamp);
        send_event(KIND_END, 3'($urandom), 16'($urandom), 16'($urandom), stamp);
    endtask

    task automatic move(input logic signed [15:0] dx, input logic signed [15:0] dy,
                        input logic [31:0] stamp);
        send_event(KIND_UPDATE, 3'($urandom), dx, dy, stamp);
    endtask

    task automatic noise();
        send_event(KIND_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    // stop offering, wait until every predicted scroll has come out, then give the
    // block time to finish events that produce nothing
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (scrolls_pending != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // all four registers, written back to back while the block is idle
    task automatic reconfigure(input logic [2:0] fingers, input logic [15:0] start_thr,
                               input logic [14:0] scroll_thr, input logic [9:0] min_gap);
        settle();
        cfg_we <= 1'b1;
        cfg_addr <= REG_REQ_FINGERS;
        cfg_wdata <= 16'(fingers);
        @(posedge clk);
        cfg_addr <= REG_START_THR;
        cfg_wdata <= start_thr;
        @(posedge clk);
        cfg_addr <= REG_SCROLL_THR;
        cfg_wdata <= 16'(scroll_thr);
        @(posedge clk);
        cfg_addr <= REG_MIN_INT;
        cfg_wdata <= 16'(min_gap);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_fingers = fingers;
        cfg_min_gap = min_gap;
        clock_ms = $urandom;
    endtask

    // mostly well-formed gestures with the configured finger count; some carry a
    // wrong count, a stray update ahead, ignored kinds inside, or no end event
    task automatic random_swipe(input int moves);
        logic [2:0] fingers;
        fingers = ($urandom_range(99) < 85) ? cfg_fingers : 3'($urandom_range(7));
        if ($urandom_range(99) < 6)
            move(pick_delta(), pick_delta(), clock_ms);
        begin_swipe(fingers, clock_ms);
        repeat (moves)
        begin
            clock_ms += pick_step();
            if ($urandom_range(99) < 3)
                noise();
            move(pick_delta(), pick_delta(), clock_ms);
        end
        if ($urandom_range(99) < 90)
            end_swipe(clock_ms);
    endtask

    task automatic random_until(input int target);
        while (items_sent < target)
            random_swipe($urandom_range(1, 12));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        src_idle_pct = 13;
        sink_idle_pct = 55;
        hold_armed = 1'b0;
        items_sent = 0;
        clock_ms = 32'd0;
        cfg_fingers = RST_REQ_FINGERS;
        cfg_min_gap = RST_MIN_INT;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset register values: three fingers, start 160,
        // scroll 16, 16 ms apart
        noise();
        move(16'sh7fff, 16'sh8000, 32'd5);      // no gesture open, ignored
        begin_swipe(3'd2, 32'd100);             // wrong finger count
        move(16'sd5000, 16'sd5000, 32'd200);    // ignored
        end_swipe(32'd210);

        begin_swipe(3'd3, 32'd1000);
        move(16'sd100, 16'sd0, 32'd1000);       // below the start magnitude
        move(16'sd100, 16'sd0, 32'd1010);       // activates, no time since stamp
        move(16'sh0000, 16'sh8000, 32'd1026);   // up, clamped to the top
        move(16'sh7fff, 16'sh0000, 32'd1042);   // right, clamped to the top
        move(-16'sd20, 16'sd10, 32'd1058);      // left, clamped to the bottom
        move(16'sd5, 16'sd5, 32'd1074);         // interval passed, no scroll, restamp
        noise();                                // ignored kind mid gesture
        move(16'sd0, 16'sd1000, 32'd1080);      // too soon after the restamp
        move(16'sd0, 16'sd1000, 32'd1090);      // down
        move(16'sd0, 16'sd17, 32'd1106);        // just over the scroll threshold
        move(16'sd16, -16'sd16, 32'd1122);      // exactly on it on both axes
        end_swipe(32'd1130);

        // timestamp wrap between activation and scroll
        begin_swipe(3'd3, 32'hffff_fff0);
        move(16'sh7fff, 16'sh7fff, 32'hffff_fff0);
        move(16'sd0, 16'sd500, 32'h0000_0005);
        move(16'sh8000, 16'sd0, 32'h0000_0400);
        end_swipe(32'h0000_0401);

        // low extremes: every nonzero update scrolls, activation update included
        reconfigure(3'd5, 16'd0, 15'd0, 10'd0);
        // long output hold-off while a burst of scrolling updates keeps coming
        hold_armed = 1'b1;
        begin_swipe(cfg_fingers, clock_ms);
        repeat (24)
        begin
            clock_ms += $urandom_range(3);
            move(pick_delta(), 16'(int'($urandom_range(1, 3000))), clock_ms);
        end
        end_swipe(clock_ms);
        random_until(200);

        // high extremes: hard to activate, only a move of -32768 on either axis scrolls
        reconfigure(3'd1, 16'd65535, 15'd32767, 10'd1000);
        random_until(330);

        // sender idles more than the receiver now
        src_idle_pct = 55;
        sink_idle_pct = 13;
        reconfigure(RST_REQ_FINGERS, RST_START_THR, RST_SCROLL_THR, RST_MIN_INT);
        random_until(500);

        // no idling on either side
        src_idle_pct = 0;
        sink_idle_pct = 0;
        reconfigure(3'd2, 16'd40, 15'd100, 10'd5);
        random_until(650);
        // sender pauses until every scroll request is out
        settle();
        random_until(720);
        reconfigure(3'd4, 16'd1000, 15'd2000, 10'd0);
        random_until(820);

        settle();
        if (failures == 0)
            $display("tb_swipe_gesture_scroll_detector passed");
        else
            $display("tb_swipe_gesture_scroll_detector failed");
        $finish;
    end

endmodule
